@@ design/csf_pkg.sv @@
// shared types and constants of the clipped span fill unit
`default_nettype none

package csf_pkg;

    // command codes of an input item
    localparam logic [1:0] CMD_PLOT  = 2'd0;
    localparam logic [1:0] CMD_SPAN  = 2'd1;
    localparam logic [1:0] CMD_ERASE = 2'd2;
    localparam logic [1:0] CMD_READ  = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_SCREEN_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_SCREEN_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_FRONT_COLOR   = 2'd2;
    localparam logic [1:0] CFG_BACK_COLOR    = 2'd3;

    // configuration reset values
    localparam logic [8:0]  RST_SCREEN_WIDTH  = 9'd100;
    localparam logic [8:0]  RST_SCREEN_HEIGHT = 9'd100;
    localparam logic [31:0] RST_FRONT_COLOR   = 32'hffff_ffff;
    localparam logic [31:0] RST_BACK_COLOR    = 32'h0000_00ff;

    // field widths
    localparam int COORD_W = 16;
    localparam int SIZE_W  = 9;
    localparam int COLOR_W = 32;

    // work kinds handed from front to back
    typedef enum logic [1:0] {
        OP_MISS  = 2'd0,
        OP_WRITE = 2'd1,
        OP_READ  = 2'd2,
        OP_ERASE = 2'd3
    } t_op;

    // control part of one queued work descriptor
    typedef struct packed {
        t_op  op;
        logic hit;
        logic vert;
    } t_ctrl;

    localparam int CTRL_W = $bits(t_ctrl);

endpackage

`default_nettype wire

@@ design/csf_queue.sv @@
// two-entry descriptor queue between the front and the back
`default_nettype none

module csf_queue #(
    parameter int DW = 8
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire logic [DW-1:0] i_data,
    output logic               o_full,
    input  wire logic          i_pop,
    output logic               o_empty,
    output logic [DW-1:0]      o_data
);

    logic [DW-1:0] r_mem [2];
    logic          r_wp;
    logic          r_rp;
    logic [1:0]    r_cnt;
    logic          s_push;
    logic          s_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rp];
    assign s_push  = i_push && !o_full;
    assign s_pop   = i_pop && !o_empty;

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (s_push) begin
                r_wp <= ~r_wp;
            end
            if (s_pop) begin
                r_rp <= ~r_rp;
            end
            if (s_push && !s_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (s_pop && !s_push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (s_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

`default_nettype wire

@@ design/csf_front.sv @@
// front end: accepts items, orders span ends, clips and builds descriptors
`default_nettype none

module csf_front
    import csf_pkg::*;
#(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    output logic                              o_in_ready,
    input  wire logic [1:0]                   i_cmd,
    input  wire logic signed [COORD_W-1:0]    i_x_first,
    input  wire logic signed [COORD_W-1:0]    i_y_first,
    input  wire logic signed [COORD_W-1:0]    i_x_second,
    input  wire logic signed [COORD_W-1:0]    i_y_second,
    input  wire logic [SIZE_W-1:0]            i_screen_width,
    input  wire logic [SIZE_W-1:0]            i_screen_height,
    output logic                              o_push,
    input  wire logic                         i_q_full,
    output t_ctrl                             o_ctrl,
    output logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0] o_addr,
    output logic [((($clog2(MAX_WIDTH)) > ($clog2(MAX_HEIGHT))) ?
                   $clog2(MAX_WIDTH) : $clog2(MAX_HEIGHT))-1:0] o_len
);

    localparam int AW = $clog2(MAX_WIDTH * MAX_HEIGHT);
    localparam int XW = $clog2(MAX_WIDTH);
    localparam int YW = $clog2(MAX_HEIGHT);
    localparam int LW = (XW > YW) ? XW : YW;
    localparam int CW = COORD_W + 2;
    localparam logic signed [CW-1:0] MW_S = CW'(MAX_WIDTH);
    localparam logic signed [CW-1:0] MH_S = CW'(MAX_HEIGHT);
    localparam logic [AW-1:0] ROW_STEP = AW'(MAX_WIDTH);

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_CLIP = 3'b010,
        F_PUSH = 3'b100
    } t_fstate;

    t_fstate r_state;
    t_fstate n_state;

    logic [1:0]                r_cmd;
    logic signed [COORD_W-1:0] r_x0;
    logic signed [COORD_W-1:0] r_y0;
    logic signed [COORD_W-1:0] r_x1;
    logic signed [COORD_W-1:0] r_y1;
    t_ctrl                     r_ctrl;
    logic [XW-1:0]             r_col;
    logic [YW-1:0]             r_row;
    logic [LW-1:0]             r_last;

    logic                      s_accept;
    logic signed [COORD_W-1:0] s_ox0, s_oy0, s_ox1, s_oy1;
    logic signed [CW-1:0]      s_sw, s_sh, s_w, s_h, s_wm1, s_hm1;
    logic signed [CW-1:0]      s_x0, s_y0, s_x1, s_y1;
    logic signed [CW-1:0]      s_xs, s_xe, s_ys, s_ye;
    logic                      s_inside, s_x_ok, s_y_ok, s_vert, s_v_go, s_h_go;
    t_ctrl                     n_ctrl;
    logic [XW-1:0]             n_col;
    logic [YW-1:0]             n_row;
    logic [LW-1:0]             n_last;

    assign o_in_ready = (r_state == F_IDLE);
    assign s_accept   = i_in_valid && o_in_ready;

    // order the span ends, other commands keep the first point
    always_comb begin
        if (i_cmd == CMD_SPAN) begin
            s_ox0 = (i_x_first > i_x_second) ? i_x_second : i_x_first;
            s_ox1 = (i_x_first > i_x_second) ? i_x_first  : i_x_second;
            s_oy0 = (i_y_first > i_y_second) ? i_y_second : i_y_first;
            s_oy1 = (i_y_first > i_y_second) ? i_y_first  : i_y_second;
        end else begin
            s_ox0 = i_x_first;
            s_ox1 = i_x_first;
            s_oy0 = i_y_first;
            s_oy1 = i_y_first;
        end
    end

    // effective screen size, limited to the store
    always_comb begin
        s_sw  = $signed({{(CW-SIZE_W){1'b0}}, i_screen_width});
        s_sh  = $signed({{(CW-SIZE_W){1'b0}}, i_screen_height});
        s_w   = (s_sw > MW_S) ? MW_S : s_sw;
        s_h   = (s_sh > MH_S) ? MH_S : s_sh;
        s_wm1 = s_w - CW'(1);
        s_hm1 = s_h - CW'(1);
    end

    // clipping against the visible screen
    always_comb begin
        s_x0 = $signed({{(CW-COORD_W){r_x0[COORD_W-1]}}, r_x0});
        s_y0 = $signed({{(CW-COORD_W){r_y0[COORD_W-1]}}, r_y0});
        s_x1 = $signed({{(CW-COORD_W){r_x1[COORD_W-1]}}, r_x1});
        s_y1 = $signed({{(CW-COORD_W){r_y1[COORD_W-1]}}, r_y1});

        s_x_ok   = !s_x0[CW-1] && (s_x0 < s_w);
        s_inside = s_x_ok && !s_y0[CW-1] && (s_y0 < s_h);
        s_y_ok   = !s_y0[CW-1] && (s_y1 < s_h);
        s_vert   = (r_x0 == r_x1);

        s_ys   = s_y0[CW-1] ? '0 : s_y0;
        s_ye   = (s_y1 > s_hm1) ? s_hm1 : s_y1;
        s_xs   = s_x0[CW-1] ? '0 : s_x0;
        s_xe   = (s_x1 > s_wm1) ? s_wm1 : s_x1;
        s_v_go = s_x_ok && (s_ys <= s_ye);
        s_h_go = s_y_ok && (s_xs <= s_xe);
    end

    // descriptor selection per command
    always_comb begin
        n_ctrl.op   = OP_MISS;
        n_ctrl.hit  = 1'b0;
        n_ctrl.vert = 1'b0;
        n_col       = s_x0[XW-1:0];
        n_row       = s_y0[YW-1:0];
        n_last      = LW'(s_x0[XW-1:0]);
        case (r_cmd)
            CMD_PLOT: begin
                n_ctrl.op  = s_inside ? OP_WRITE : OP_MISS;
                n_ctrl.hit = s_inside;
            end
            CMD_READ: begin
                n_ctrl.op  = s_inside ? OP_READ : OP_MISS;
                n_ctrl.hit = s_inside;
            end
            CMD_ERASE: begin
                n_ctrl.op = OP_ERASE;
            end
            default: begin
                if (s_vert) begin
                    n_ctrl.op   = s_v_go ? OP_WRITE : OP_MISS;
                    n_ctrl.hit  = s_v_go;
                    n_ctrl.vert = 1'b1;
                    n_row       = s_ys[YW-1:0];
                    n_last      = LW'(s_ye[YW-1:0]);
                end else begin
                    n_ctrl.op  = s_h_go ? OP_WRITE : OP_MISS;
                    n_ctrl.hit = s_h_go;
                    n_col      = s_xs[XW-1:0];
                    n_last     = LW'(s_xe[XW-1:0]);
                end
            end
        endcase
    end

    // start address and run length
    assign o_ctrl = r_ctrl;
    assign o_addr = AW'(r_row) * ROW_STEP + AW'(r_col);
    assign o_len  = r_ctrl.vert ? (r_last - LW'(r_row)) : (r_last - LW'(r_col));
    assign o_push = (r_state == F_PUSH) && !i_q_full;

    // front sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            F_IDLE: begin
                if (s_accept) begin
                    n_state = F_CLIP;
                end
            end
            F_CLIP: begin
                n_state = F_PUSH;
            end
            F_PUSH: begin
                if (!i_q_full) begin
                    n_state = F_IDLE;
                end
            end
            default: begin
                n_state = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // item and descriptor registers
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_cmd <= i_cmd;
            r_x0  <= s_ox0;
            r_y0  <= s_oy0;
            r_x1  <= s_ox1;
            r_y1  <= s_oy1;
        end
        if (r_state == F_CLIP) begin
            r_ctrl <= n_ctrl;
            r_col  <= n_col;
            r_row  <= n_row;
            r_last <= n_last;
        end
    end

endmodule

`default_nettype wire

@@ design/csf_back.sv @@
// back end: erase sweep, pixel writes and reads, result register
`default_nettype none

module csf_back
    import csf_pkg::*;
#(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_q_empty,
    output logic                              o_pop,
    input  wire t_ctrl                        i_ctrl,
    input  wire logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0] i_addr,
    input  wire logic [((($clog2(MAX_WIDTH)) > ($clog2(MAX_HEIGHT))) ?
                        $clog2(MAX_WIDTH) : $clog2(MAX_HEIGHT))-1:0] i_len,
    input  wire logic [COLOR_W-1:0]           i_front_color,
    input  wire logic [COLOR_W-1:0]           i_back_color,
    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output logic [COLOR_W-1:0]                o_pixel_value,
    output logic                              o_on_screen
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int YW    = $clog2(MAX_HEIGHT);
    localparam int LW    = (XW > YW) ? XW : YW;
    localparam logic [AW-1:0] ROW_STEP  = AW'(MAX_WIDTH);
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

    typedef enum logic [4:0] {
        B_IDLE  = 5'b00001,
        B_SWEEP = 5'b00010,
        B_WRITE = 5'b00100,
        B_READ  = 5'b01000,
        B_DONE  = 5'b10000
    } t_bstate;

    t_bstate r_state, n_state;
    t_ctrl   r_ctrl, n_ctrl;
    logic [AW-1:0] r_addr, n_addr;
    logic [LW-1:0] r_left, n_left;
    logic [AW-1:0] r_sweep, n_sweep;
    logic          r_pend, n_pend;
    logic          r_out_valid, n_out_valid;
    logic [COLOR_W-1:0] r_pixel, n_pixel;
    logic          r_on, n_on;

    logic [COLOR_W-1:0] r_mem [DEPTH];
    logic [COLOR_W-1:0] r_rd_data;
    logic               s_we;
    logic [AW-1:0]      s_wa;
    logic [COLOR_W-1:0] s_wd;
    logic               s_rd;
    logic               s_slot_free;

    assign o_out_valid   = r_out_valid;
    assign o_pixel_value = r_pixel;
    assign o_on_screen   = r_on;
    assign s_slot_free   = !r_out_valid || i_out_ready;

    // first step of a work kind once the store is clean
    function automatic t_bstate start_of(input t_op op);
        t_bstate st;
        st = B_DONE;
        case (op)
            OP_WRITE: st = B_WRITE;
            OP_READ:  st = B_READ;
            default:  st = B_DONE;
        endcase
        return st;
    endfunction

    // back sequencer
    always_comb begin
        n_state     = r_state;
        n_ctrl      = r_ctrl;
        n_addr      = r_addr;
        n_left      = r_left;
        n_sweep     = r_sweep;
        n_pend      = r_pend;
        n_out_valid = r_out_valid && !i_out_ready;
        n_pixel     = r_pixel;
        n_on        = r_on;
        o_pop       = 1'b0;
        s_we        = 1'b0;
        s_wa        = r_addr;
        s_wd        = i_front_color;
        s_rd        = 1'b0;
        unique case (r_state)
            B_IDLE: begin
                if (!i_q_empty) begin
                    o_pop   = 1'b1;
                    n_ctrl  = i_ctrl;
                    n_addr  = i_addr;
                    n_left  = i_len;
                    n_sweep = '0;
                    if (i_ctrl.op == OP_ERASE) begin
                        n_pend  = 1'b1;
                        n_state = B_DONE;
                    end else if (r_pend) begin
                        n_state = B_SWEEP;
                    end else begin
                        n_state = start_of(i_ctrl.op);
                    end
                end
            end
            B_SWEEP: begin
                s_we = 1'b1;
                s_wa = r_sweep;
                s_wd = i_back_color;
                if (r_sweep == LAST_ADDR) begin
                    n_pend  = 1'b0;
                    n_state = start_of(r_ctrl.op);
                end else begin
                    n_sweep = r_sweep + AW'(1);
                end
            end
            B_WRITE: begin
                s_we = 1'b1;
                if (r_left == '0) begin
                    n_state = B_DONE;
                end else begin
                    n_addr = r_addr + (r_ctrl.vert ? ROW_STEP : AW'(1));
                    n_left = r_left - LW'(1);
                end
            end
            B_READ: begin
                s_rd    = 1'b1;
                n_state = B_DONE;
            end
            B_DONE: begin
                if (s_slot_free) begin
                    n_out_valid = 1'b1;
                    n_pixel     = (r_ctrl.op == OP_READ) ? r_rd_data : '0;
                    n_on        = r_ctrl.hit;
                    n_state     = B_IDLE;
                end
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_pend      <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    // descriptor and result registers
    always_ff @(posedge i_clk) begin
        r_ctrl  <= n_ctrl;
        r_addr  <= n_addr;
        r_left  <= n_left;
        r_sweep <= n_sweep;
        r_pixel <= n_pixel;
        r_on    <= n_on;
    end

    // pixel store, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (s_we) begin
            r_mem[s_wa] <= s_wd;
        end
        if (s_rd) begin
            r_rd_data <= r_mem[r_addr];
        end
    end

endmodule

`default_nettype wire

@@ design/clipped_span_fill_unit.sv @@
// top level of the clipped span fill unit: configuration registers and wiring
//
// Drawing engine over a MAX_WIDTH x MAX_HEIGHT store of 32-bit RGBA words.
// Input channel (i_in_valid / o_in_ready) takes one command item: plot,
// span, erase request or pixel read. Every item gives exactly one result
// item on the output channel (o_out_valid / i_out_ready), in order.
// Configuration writes (i_cfg_valid / o_cfg_ready) are always taken and
// must only be issued while the block is idle.
// Steps: the front accepts an item, clips it, then pushes the descriptor with
// its start address and run length once the queue has room; the back pops
// the descriptor, writes each pixel of a plot or span in turn or reads one
// word, then posts the result when the result register is free.
// Reset and every erase request leave an erase pending; the next plot,
// span or read first sweeps the whole store with back_color, one word per
// cycle. A stalled receiver holds the result register; the front keeps
// taking items while the two-entry descriptor queue has room and holds
// o_in_ready low while a descriptor waits for a free entry.
`default_nettype none

module clipped_span_fill_unit
    import csf_pkg::*;
#(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_in_valid,
    output logic                           o_in_ready,
    input  wire logic [1:0]                i_cmd,
    input  wire logic signed [COORD_W-1:0] i_x_first,
    input  wire logic signed [COORD_W-1:0] i_y_first,
    input  wire logic signed [COORD_W-1:0] i_x_second,
    input  wire logic signed [COORD_W-1:0] i_y_second,
    output logic                           o_out_valid,
    input  wire logic                      i_out_ready,
    output logic [COLOR_W-1:0]             o_pixel_value,
    output logic                           o_on_screen,
    input  wire logic                      i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire logic [1:0]                i_cfg_index,
    input  wire logic [COLOR_W-1:0]        i_cfg_data
);

    localparam int AW = $clog2(MAX_WIDTH * MAX_HEIGHT);
    localparam int XW = $clog2(MAX_WIDTH);
    localparam int YW = $clog2(MAX_HEIGHT);
    localparam int LW = (XW > YW) ? XW : YW;
    localparam int DW = CTRL_W + AW + LW;

    logic [SIZE_W-1:0]  r_screen_width;
    logic [SIZE_W-1:0]  r_screen_height;
    logic [COLOR_W-1:0] r_front_color;
    logic [COLOR_W-1:0] r_back_color;

    logic          s_push, s_full, s_pop, s_empty;
    t_ctrl         s_f_ctrl, s_b_ctrl;
    logic [AW-1:0] s_f_addr, s_b_addr;
    logic [LW-1:0] s_f_len, s_b_len;
    logic [DW-1:0] s_q_in, s_q_out;

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_screen_width  <= RST_SCREEN_WIDTH;
            r_screen_height <= RST_SCREEN_HEIGHT;
            r_front_color   <= RST_FRONT_COLOR;
            r_back_color    <= RST_BACK_COLOR;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_SCREEN_WIDTH:  r_screen_width  <= i_cfg_data[SIZE_W-1:0];
                CFG_SCREEN_HEIGHT: r_screen_height <= i_cfg_data[SIZE_W-1:0];
                CFG_FRONT_COLOR:   r_front_color   <= i_cfg_data;
                CFG_BACK_COLOR:    r_back_color    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // front end
    csf_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_cmd           (i_cmd),
        .i_x_first       (i_x_first),
        .i_y_first       (i_y_first),
        .i_x_second      (i_x_second),
        .i_y_second      (i_y_second),
        .i_screen_width  (r_screen_width),
        .i_screen_height (r_screen_height),
        .o_push          (s_push),
        .i_q_full        (s_full),
        .o_ctrl          (s_f_ctrl),
        .o_addr          (s_f_addr),
        .o_len           (s_f_len)
    );

    // descriptor queue
    assign s_q_in = {s_f_ctrl, s_f_addr, s_f_len};
    assign {s_b_ctrl, s_b_addr, s_b_len} = s_q_out;

    csf_queue #(
        .DW (DW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s_push),
        .i_data  (s_q_in),
        .o_full  (s_full),
        .i_pop   (s_pop),
        .o_empty (s_empty),
        .o_data  (s_q_out)
    );

    // back end
    csf_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_empty     (s_empty),
        .o_pop         (s_pop),
        .i_ctrl        (s_b_ctrl),
        .i_addr        (s_b_addr),
        .i_len         (s_b_len),
        .i_front_color (r_front_color),
        .i_back_color  (r_back_color),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_pixel_value (o_pixel_value),
        .o_on_screen   (o_on_screen)
    );

endmodule

`default_nettype wire

@@ sim/tb.sv @@
// testbench of the clipped span fill unit: directed and random drawing with a shadow framebuffer
module tb;
    import csf_pkg::*;

    localparam int MAX_W       = 256;
    localparam int MAX_H       = 256;
    localparam int QUIET_LIMIT = 250000;
    localparam int PHASE_ITEMS = 182;

    typedef struct {
        logic [1:0]                cmd;
        logic signed [COORD_W-1:0] xf;
        logic signed [COORD_W-1:0] yf;
        logic signed [COORD_W-1:0] xs;
        logic signed [COORD_W-1:0] ys;
    } t_draw_cmd;

    typedef struct {
        logic [COLOR_W-1:0] pixel;
        logic               hit;
    } t_draw_outcome;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_in_valid = 1'b0;
    logic                      o_in_ready;
    logic [1:0]                i_cmd = CMD_PLOT;
    logic signed [COORD_W-1:0] i_x_first = '0;
    logic signed [COORD_W-1:0] i_y_first = '0;
    logic signed [COORD_W-1:0] i_x_second = '0;
    logic signed [COORD_W-1:0] i_y_second = '0;
    logic                      o_out_valid;
    logic                      i_out_ready = 1'b0;
    logic [COLOR_W-1:0]        o_pixel_value;
    logic                      o_on_screen;
    logic                      i_cfg_valid = 1'b0;
    logic                      o_cfg_ready;
    logic [1:0]                i_cfg_index = CFG_SCREEN_WIDTH;
    logic [COLOR_W-1:0]        i_cfg_data = '0;

    // shadow copy of the framebuffer and its registers
    logic [COLOR_W-1:0] shadow_fb [MAX_W*MAX_H];
    logic               erase_owed = 1'b1;
    logic [SIZE_W-1:0]  shadow_width = RST_SCREEN_WIDTH;
    logic [SIZE_W-1:0]  shadow_height = RST_SCREEN_HEIGHT;
    logic [COLOR_W-1:0] shadow_front = RST_FRONT_COLOR;
    logic [COLOR_W-1:0] shadow_back = RST_BACK_COLOR;

    t_draw_cmd     cmd_backlog[$];
    t_draw_outcome expected_outcomes[$];

    int mismatches = 0;
    int cmds_queued = 0;
    int cmds_sent = 0;
    int results_checked = 0;
    int sweeps_seen = 0;
    int settings_used = 0;
    int quiet_cycles = 0;
    int burst_left = 1;
    int gap_left = 0;
    int stall_tick = 0;
    int stall_mode = 0;

    clipped_span_fill_unit #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_cmd         (i_cmd),
        .i_x_first     (i_x_first),
        .i_y_first     (i_y_first),
        .i_x_second    (i_x_second),
        .i_y_second    (i_y_second),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_pixel_value (o_pixel_value),
        .o_on_screen   (o_on_screen),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // clock
    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // shadow framebuffer update and outcome of one accepted command
    function automatic void predict_command(t_draw_cmd c);
        int ew, eh, x0, y0, x1, y1, t, i;
        logic [COLOR_W-1:0] px;
        logic hit;
        logic on_grid;
        ew = (shadow_width > MAX_W) ? MAX_W : int'(shadow_width);
        eh = (shadow_height > MAX_H) ? MAX_H : int'(shadow_height);
        px = '0;
        hit = 1'b0;
        if (c.cmd == CMD_ERASE) begin
            erase_owed = 1'b1;
        end else begin
            // deferred erase uses the back colour current now
            if (erase_owed) begin
                foreach (shadow_fb[n]) shadow_fb[n] = shadow_back;
                erase_owed = 1'b0;
                sweeps_seen++;
            end
            x0 = c.xf;
            y0 = c.yf;
            x1 = c.xs;
            y1 = c.ys;
            on_grid = (x0 >= 0) && (x0 < ew) && (y0 >= 0) && (y0 < eh);
            case (c.cmd)
                CMD_PLOT: begin
                    if (on_grid) begin
                        shadow_fb[y0*MAX_W + x0] = shadow_front;
                        hit = 1'b1;
                    end
                end
                CMD_READ: begin
                    if (on_grid) begin
                        px = shadow_fb[y0*MAX_W + x0];
                        hit = 1'b1;
                    end
                end
                default: begin
                    if (x0 > x1) begin
                        t = x0; x0 = x1; x1 = t;
                    end
                    if (y0 > y1) begin
                        t = y0; y0 = y1; y1 = t;
                    end
                    if (x0 == x1) begin
                        // vertical: reject off-screen column, clip rows
                        if (x0 >= 0 && x0 < ew) begin
                            if (y0 < 0) y0 = 0;
                            if (y1 > eh - 1) y1 = eh - 1;
                            for (i = y0; i <= y1; i++) begin
                                shadow_fb[i*MAX_W + x0] = shadow_front;
                                hit = 1'b1;
                            end
                        end
                    end else if (y0 >= 0 && y1 < eh) begin
                        // horizontal on the upper row, columns clipped
                        if (x0 < 0) x0 = 0;
                        if (x1 > ew - 1) x1 = ew - 1;
                        for (i = x0; i <= x1; i++) begin
                            shadow_fb[y0*MAX_W + i] = shadow_front;
                            hit = 1'b1;
                        end
                    end
                end
            endcase
        end
        expected_outcomes.push_back('{px, hit});
    endfunction

    // command driver: bursts of random length with random gaps
    always @(posedge i_clk) begin
        t_draw_cmd c;
        logic busy;
        busy = i_in_valid;
        if (!i_rst_n) begin
            busy = 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                predict_command('{i_cmd, i_x_first, i_y_first, i_x_second, i_y_second});
                cmds_sent++;
                busy = 1'b0;
            end
            if (!busy) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (cmd_backlog.size() != 0) begin
                    c = cmd_backlog.pop_front();
                    i_cmd <= c.cmd;
                    i_x_first <= c.xf;
                    i_y_first <= c.yf;
                    i_x_second <= c.xs;
                    i_y_second <= c.ys;
                    busy = 1'b1;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end
            end
        end
        i_in_valid <= busy;
    end

    // result monitor and receiver stall pattern
    always @(posedge i_clk) begin
        t_draw_outcome want;
        logic rdy;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_outcomes.size() == 0) begin
                $error("result with no command waiting: pixel_value %h on_screen %b",
                       o_pixel_value, o_on_screen);
                mismatches++;
            end else begin
                want = expected_outcomes.pop_front();
                if (o_pixel_value !== want.pixel) begin
                    $error("pixel_value: expected %h, got %h", want.pixel, o_pixel_value);
                    mismatches++;
                end
                if (o_on_screen !== want.hit) begin
                    $error("on_screen: expected %b, got %b", want.hit, o_on_screen);
                    mismatches++;
                end
                results_checked++;
            end
        end
        stall_tick++;
        if (stall_tick % 64 == 0) stall_mode = $urandom_range(0, 3);
        case (stall_mode)
            0: rdy = 1'b1;
            1: rdy = ($urandom_range(0, 3) != 0);
            2: rdy = (stall_tick % 4 == 0);
            default: rdy = ($urandom_range(0, 3) == 0);
        endcase
        i_out_ready <= rdy;
    end

    // watchdog on handshake activity
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", QUIET_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic queue_cmd(logic [1:0] cmd, int xf, int yf, int xs, int ys);
        cmd_backlog.push_back('{cmd, COORD_W'(xf), COORD_W'(yf), COORD_W'(xs), COORD_W'(ys)});
        cmds_queued++;
    endtask

    // block idle: nothing queued, nothing in flight, every result back
    task automatic wait_idle();
        while (cmd_backlog.size() != 0 || i_in_valid || expected_outcomes.size() != 0 ||
               results_checked < cmds_queued)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [COLOR_W-1:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_SCREEN_WIDTH:  shadow_width = val[SIZE_W-1:0];
            CFG_SCREEN_HEIGHT: shadow_height = val[SIZE_W-1:0];
            CFG_FRONT_COLOR:   shadow_front = val;
            default:           shadow_back = val;
        endcase
    endtask

    // coordinate biased to the visible range and its edges
    function automatic int pick_coord(int extent);
        int lim;
        lim = (extent < 1) ? 1 : extent;
        case ($urandom_range(0, 9))
            0: return int'($signed(COORD_W'($urandom)));
            1: return -int'($urandom_range(1, 8));
            2: return lim - 1 + int'($urandom_range(0, 3));
            default: return int'($urandom_range(0, lim - 1));
        endcase
    endfunction

    task automatic queue_random_cmd();
        int ew, eh, pick, xf, yf, xs, ys;
        ew = (shadow_width > MAX_W) ? MAX_W : int'(shadow_width);
        eh = (shadow_height > MAX_H) ? MAX_H : int'(shadow_height);
        pick = $urandom_range(0, 99);
        xf = pick_coord(ew);
        yf = pick_coord(eh);
        xs = int'($signed(COORD_W'($urandom)));
        ys = int'($signed(COORD_W'($urandom)));
        if (pick < 30) begin
            queue_cmd(CMD_PLOT, xf, yf, xs, ys);
        end else if (pick < 65) begin
            if ($urandom_range(0, 4) < 2) begin
                // vertical
                queue_cmd(CMD_SPAN, xf, yf, xf, pick_coord(eh));
            end else begin
                // horizontal, ends mostly short
                xs = ($urandom_range(0, 2) == 0) ? pick_coord(ew)
                                                 : xf + int'($urandom_range(0, 16)) - 8;
                ys = ($urandom_range(0, 3) == 0) ? pick_coord(eh) : yf;
                queue_cmd(CMD_SPAN, xf, yf, xs, ys);
            end
        end else begin
            queue_cmd(CMD_READ, xf, yf, xs, ys);
        end
    endtask

    // one screen setting, then a batch of random commands
    task automatic run_phase(logic [SIZE_W-1:0] w, logic [SIZE_W-1:0] h,
                             logic [COLOR_W-1:0] front, logic [COLOR_W-1:0] back,
                             int n_items);
        int erase_at;
        wait_idle();
        write_reg(CFG_SCREEN_WIDTH, {23'($urandom), w});
        write_reg(CFG_SCREEN_HEIGHT, {23'($urandom), h});
        write_reg(CFG_FRONT_COLOR, front);
        write_reg(CFG_BACK_COLOR, back);
        settings_used++;
        erase_at = ($urandom_range(0, 1) == 0) ? -1 : int'($urandom_range(0, n_items - 1));
        for (int k = 0; k < n_items; k++) begin
            if (k == erase_at)
                queue_cmd(CMD_ERASE, int'($signed(COORD_W'($urandom))),
                          int'($signed(COORD_W'($urandom))), 0, 0);
            else
                queue_random_cmd();
        end
        wait_idle();
    endtask

    // stimulus sequence
    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        settings_used = 1;

        // reset setting: first read triggers the pending erase
        queue_cmd(CMD_READ, 0, 0, 12345, -7);
        queue_cmd(CMD_PLOT, 0, 0, -1, -1);
        queue_cmd(CMD_READ, 0, 0, 0, 0);
        queue_cmd(CMD_PLOT, 99, 99, 0, 0);
        queue_cmd(CMD_READ, 99, 99, 0, 0);
        // plots off every edge and at the field extremes
        queue_cmd(CMD_PLOT, 100, 0, 0, 0);
        queue_cmd(CMD_PLOT, -1, 5, 0, 0);
        queue_cmd(CMD_PLOT, -32768, 32767, 0, 0);
        queue_cmd(CMD_PLOT, 32767, -32768, 0, 0);
        queue_cmd(CMD_READ, 100, 100, 0, 0);
        // horizontal spans: full clip, rejected top and bottom rows
        queue_cmd(CMD_SPAN, -32768, 10, 32767, 10);
        queue_cmd(CMD_READ, 50, 10, 0, 0);
        queue_cmd(CMD_SPAN, 2, -1, 9, 5);
        queue_cmd(CMD_SPAN, 2, 5, 9, 100);
        // vertical spans: full clip, columns off screen, clipped away
        queue_cmd(CMD_SPAN, 3, -32768, 3, 32767);
        queue_cmd(CMD_READ, 3, 99, 0, 0);
        queue_cmd(CMD_SPAN, 100, 1, 100, 8);
        queue_cmd(CMD_SPAN, -1, 1, -1, 8);
        queue_cmd(CMD_SPAN, 5, 300, 5, 200);
        queue_cmd(CMD_SPAN, 5, -3, 5, -10);
        // reversed ends
        queue_cmd(CMD_SPAN, 20, 7, 10, 3);
        queue_cmd(CMD_READ, 15, 3, 0, 0);
        queue_cmd(CMD_ERASE, 1, 1, 1, 1);
        wait_idle();
        // erase fill takes the back colour written after the request
        write_reg(CFG_BACK_COLOR, 32'h1234_5678);
        queue_cmd(CMD_READ, 0, 0, 0, 0);
        queue_cmd(CMD_READ, 15, 3, 0, 0);
        wait_idle();

        // random phases over extreme and ordinary settings
        run_phase(9'd256, 9'd256, 32'hffff_ffff, 32'h0000_0000, PHASE_ITEMS);
        run_phase(9'd0, 9'd50, $urandom, $urandom, PHASE_ITEMS);
        run_phase(9'd8, 9'd6, 32'h0000_0000, 32'hffff_ffff, PHASE_ITEMS);
        run_phase(9'd511, 9'd300, $urandom, $urandom, PHASE_ITEMS);
        run_phase(9'd1, 9'd1, $urandom, $urandom, PHASE_ITEMS);
        run_phase(9'd30, 9'd0, $urandom, $urandom, PHASE_ITEMS);
        run_phase(SIZE_W'($urandom_range(1, 256)), SIZE_W'($urandom_range(1, 256)),
                  $urandom, $urandom, PHASE_ITEMS);

        repeat (64) @(posedge i_clk);
        if (expected_outcomes.size() != 0) begin
            $error("%0d expected results never arrived", expected_outcomes.size());
            mismatches++;
        end
        $display("%0d commands sent, %0d results checked, %0d mismatches",
                 cmds_sent, results_checked, mismatches);
        $display("%0d screen settings used, %0d full-store erases predicted",
                 settings_used, sweeps_seen);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
